/* src/bio_pkg.sv */
// Shared types, constants and port codes for the board I/O port controller.
package bio_pkg;

  localparam int KEY_FIFO_DEPTH = 16;
  localparam int FIFO_IDX_W     = (KEY_FIFO_DEPTH > 1) ? $clog2(KEY_FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W     = $clog2(KEY_FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_PORT_WR = 3'd0,
    OP_PORT_RD = 3'd1,
    OP_KEY     = 3'd2,
    OP_TICK    = 3'd3,
    OP_SERIAL  = 3'd4,
    OP_BUTTON  = 3'd5
  } bio_op_t;

  // forward targets
  localparam logic [2:0] TGT_LEDS   = 3'd0;
  localparam logic [2:0] TGT_LCD    = 3'd1;
  localparam logic [2:0] TGT_SERIAL = 3'd2;
  localparam logic [2:0] TGT_VIDEO  = 3'd3;
  localparam logic [2:0] TGT_SOUND  = 3'd4;

  // port numbers
  localparam logic [7:0] PORT_LEDS      = 8'h00;
  localparam logic [7:0] PORT_LCD       = 8'h10;
  localparam logic [7:0] PORT_VIDEO_LO  = 8'h50;
  localparam logic [7:0] PORT_VIDEO_HI  = 8'h53;
  localparam logic [7:0] PORT_TIMER     = 8'h54;
  localparam logic [7:0] PORT_KEYBOARD  = 8'h55;
  localparam logic [7:0] PORT_SND_ADDR  = 8'h56;
  localparam logic [7:0] PORT_SND_DATA  = 8'h57;
  localparam logic [7:0] PORT_SER_CTRL  = 8'h58;
  localparam logic [7:0] PORT_SER_DATA  = 8'h59;
  localparam logic [7:0] PORT_STATUS    = 8'h5F;

  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] BYTE_NONE = 8'hFF;

  // status flag bit positions
  localparam int FLAG_KEY    = 0;
  localparam int FLAG_TIMER  = 1;
  localparam int FLAG_SERIAL = 2;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] port_address;
    logic [7:0] write_data;
    logic [2:0] button_index;
    logic       button_pressed;
  } bio_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] irq_status;
    logic       forward_valid;
    logic [2:0] forward_target;
    logic [7:0] forward_register;
    logic [7:0] forward_data;
    logic       external_read;
    logic       input_accepted;
  } bio_out_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] push_data;
  } fifo_ctl_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic       last;
    logic [7:0] head;
  } fifo_sts_t;

endpackage

/* src/bio_key_fifo.sv */
// Keyboard scancode FIFO: register storage, pointers and fill count.
module bio_key_fifo import bio_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  fifo_ctl_t ctl,
  output fifo_sts_t sts
);

  logic [7:0]            mem [KEY_FIFO_DEPTH];
  logic [FIFO_IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [FIFO_IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;

  localparam logic [FIFO_IDX_W-1:0] IDX_LAST = FIFO_IDX_W'(KEY_FIFO_DEPTH - 1);
  localparam logic [FIFO_CNT_W-1:0] CNT_FULL = FIFO_CNT_W'(KEY_FIFO_DEPTH);

  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    count_nxt  = count_r;
    // push and pop never come in the same beat
    if (ctl.push) begin
      wr_idx_nxt = (wr_idx_r == IDX_LAST) ? '0 : wr_idx_r + 1'b1;
      count_nxt  = count_r + 1'b1;
    end else if (ctl.pop) begin
      rd_idx_nxt = (rd_idx_r == IDX_LAST) ? '0 : rd_idx_r + 1'b1;
      count_nxt  = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      count_r  <= '0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_idx_r] <= ctl.push_data;
    end
  end

  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == CNT_FULL);
  assign sts.last  = (count_r == FIFO_CNT_W'(1));
  assign sts.head  = mem[rd_idx_r];

endmodule

/* src/bio_core.sv */
// Event decode, port register file and result formation for one beat.
module bio_core import bio_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  bio_in_t   item,
  input  fifo_sts_t fifo_sts,
  output fifo_ctl_t fifo_ctl,
  output bio_out_t  result
);

  logic [2:0] status_r, status_nxt;
  logic [7:0] timer_ctrl_r, timer_ctrl_nxt;
  logic [7:0] serial_ctrl_r, serial_ctrl_nxt;
  logic [7:0] serial_latch_r, serial_latch_nxt;
  logic [7:0] sound_addr_r, sound_addr_nxt;
  logic [7:0] button_r, button_nxt;
  logic [7:0] ser_rd;

  always_comb begin
    status_nxt       = status_r;
    timer_ctrl_nxt   = timer_ctrl_r;
    serial_ctrl_nxt  = serial_ctrl_r;
    serial_latch_nxt = serial_latch_r;
    sound_addr_nxt   = sound_addr_r;
    button_nxt       = button_r;
    fifo_ctl         = '0;
    fifo_ctl.push_data = item.write_data;
    result           = '0;
    ser_rd           = (serial_latch_r == CHAR_LF) ? CHAR_CR : serial_latch_r;

    unique case (bio_op_t'(item.operation))
      OP_PORT_WR: begin
        priority if (item.port_address == PORT_LEDS) begin
          result.forward_valid  = 1'b1;
          result.forward_target = TGT_LEDS;
          result.forward_data   = item.write_data;
        end else if (item.port_address == PORT_LCD) begin
          result.forward_valid  = 1'b1;
          result.forward_target = TGT_LCD;
          result.forward_data   = item.write_data;
        end else if (item.port_address == PORT_SER_DATA) begin
          if (item.write_data != CHAR_CR) begin
            result.forward_valid  = 1'b1;
            result.forward_target = TGT_SERIAL;
            result.forward_data   = item.write_data;
          end
        end else if (item.port_address >= PORT_VIDEO_LO &&
                     item.port_address <= PORT_VIDEO_HI) begin
          result.forward_valid    = 1'b1;
          result.forward_target   = TGT_VIDEO;
          result.forward_register = item.port_address;
          result.forward_data     = item.write_data;
        end else if (item.port_address == PORT_TIMER) begin
          timer_ctrl_nxt = item.write_data;
        end else if (item.port_address == PORT_SER_CTRL) begin
          serial_ctrl_nxt = item.write_data;
        end else if (item.port_address == PORT_SND_ADDR) begin
          sound_addr_nxt = item.write_data;
        end else if (item.port_address == PORT_SND_DATA) begin
          result.forward_valid    = 1'b1;
          result.forward_target   = TGT_SOUND;
          result.forward_register = sound_addr_r;
          result.forward_data     = item.write_data;
        end else begin
        end
      end
      OP_PORT_RD: begin
        priority if (item.port_address == PORT_VIDEO_LO) begin
          result.external_read = 1'b1;
        end else if (item.port_address == PORT_LEDS) begin
          result.read_data = button_r;
        end else if (item.port_address == PORT_SER_CTRL) begin
          result.read_data = '0;
        end else if (item.port_address == PORT_STATUS) begin
          result.read_data = {5'b0, status_r};
        end else if (item.port_address == PORT_KEYBOARD) begin
          fifo_ctl.pop     = !fifo_sts.empty;
          result.read_data = fifo_sts.empty ? BYTE_NONE : fifo_sts.head;
          // flag drops once the FIFO is drained
          if (fifo_sts.empty || fifo_sts.last) begin
            status_nxt[FLAG_KEY] = 1'b0;
          end
        end else if (item.port_address == PORT_TIMER) begin
          status_nxt[FLAG_TIMER] = 1'b0;
          result.read_data       = BYTE_NONE;
        end else if (item.port_address == PORT_SER_DATA) begin
          status_nxt[FLAG_SERIAL] = 1'b0;
          serial_latch_nxt        = ser_rd;
          result.read_data        = ser_rd;
        end else begin
          result.read_data = BYTE_NONE;
        end
      end
      OP_KEY: begin
        if (!fifo_sts.full) begin
          fifo_ctl.push         = 1'b1;
          status_nxt[FLAG_KEY]  = 1'b1;
          result.input_accepted = 1'b1;
        end
      end
      OP_TICK: begin
        if (timer_ctrl_r[0]) begin
          status_nxt[FLAG_TIMER] = 1'b1;
        end
      end
      OP_SERIAL: begin
        if (serial_ctrl_r[1:0] == 2'b11 && !status_r[FLAG_SERIAL]) begin
          serial_latch_nxt        = item.write_data;
          status_nxt[FLAG_SERIAL] = 1'b1;
          result.input_accepted   = 1'b1;
        end
      end
      OP_BUTTON: begin
        button_nxt[item.button_index] = !item.button_pressed;
      end
      default: begin
      end
    endcase

    result.irq_status = status_nxt;
    if (!step) begin
      fifo_ctl.push = 1'b0;
      fifo_ctl.pop  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r       <= '0;
      timer_ctrl_r   <= '0;
      serial_ctrl_r  <= '0;
      serial_latch_r <= '0;
      sound_addr_r   <= '0;
      button_r       <= 8'hFF;
    end else if (step) begin
      status_r       <= status_nxt;
      timer_ctrl_r   <= timer_ctrl_nxt;
      serial_ctrl_r  <= serial_ctrl_nxt;
      serial_latch_r <= serial_latch_nxt;
      sound_addr_r   <= sound_addr_nxt;
      button_r       <= button_nxt;
    end
  end

endmodule

/* src/board_io_port_controller.sv */
// Board I/O port controller: input register, event logic, result register.
// An accepted beat is held in the input register, then in the result register.
// One beat per cycle unless out_ready stalls; state update is one decode pass.
// in_ready stays high while the result register is free or being emptied.
// Reset (rst_n low, synchronous) empties both stages, clears the status, control
// and latch registers and the keyboard FIFO, and sets all buttons released.
module board_io_port_controller import bio_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bio_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output bio_out_t out_data
);

  logic      s1_valid_r;
  bio_in_t   s1_item_r;
  logic      out_valid_r;
  bio_out_t  out_item_r;
  logic      advance;
  logic      step;
  bio_out_t  result;
  fifo_ctl_t fifo_ctl;
  fifo_sts_t fifo_sts;

  assign advance  = !out_valid_r || out_ready;
  assign step     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    if (step) begin
      out_item_r <= result;
    end
  end

  bio_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .item     (s1_item_r),
    .fifo_sts (fifo_sts),
    .fifo_ctl (fifo_ctl),
    .result   (result)
  );

  bio_key_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (fifo_ctl),
    .sts   (fifo_sts)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

/* src/bio_checker.sv */
// Port-level checks for the board I/O port controller, bound to the top level.
module bio_checker import bio_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input bio_out_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_fwd_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.forward_valid |->
      out_data.forward_target == 3'd0 && out_data.forward_register == 8'd0 &&
      out_data.forward_data == 8'd0)
    else $error("forward fields set without forward_valid");

  a_fwd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.forward_valid |->
      out_data.forward_target <= TGT_SOUND && !out_data.input_accepted &&
      !out_data.external_read && out_data.read_data == 8'd0)
    else $error("forward beat carries read or accept fields");

  a_ext_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.external_read |->
      out_data.read_data == 8'd0 && !out_data.input_accepted)
    else $error("external read returned data");

endmodule

bind board_io_port_controller bio_checker u_bio_checker (.*);

/* verif/board_io_port_controller_tb.sv */
// Self-checking testbench for the board I/O port controller: directed and random traffic plus a scoreboard.
module board_io_port_controller_tb;
  import bio_pkg::*;

  localparam logic [2:0] OP_UNDEF_LO   = 3'd6;
  localparam logic [2:0] OP_UNDEF_HI   = 3'd7;
  localparam logic [7:0] PORT_UNMAPPED = 8'hC3;
  localparam int unsigned TOTAL_BEATS  = 1550;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  class bio_scoreboard;
    logic [2:0] flags;
    logic [7:0] tmr_ctl, ser_ctl, ser_latch, snd_addr, buttons;
    logic [7:0] keys [KEY_FIFO_DEPTH];
    int unsigned key_wr, key_rd, key_cnt;
    bio_out_t expected_q[$];
    int unsigned mismatches, results_seen, keys_dropped, serial_taken, forwards, ext_reads;

    function new();
      flags = '0;
      tmr_ctl = '0;
      ser_ctl = '0;
      ser_latch = '0;
      snd_addr = '0;
      buttons = BYTE_NONE;
      key_wr = 0;
      key_rd = 0;
      key_cnt = 0;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
    endtask

    // advance the shadow state by one event and queue the expected result
    function void note_input(bio_in_t it);
      bio_out_t r;
      logic [7:0] p, d, freg;
      logic [2:0] tgt;
      bit fwd;
      r = '0;
      p = it.port_address;
      d = it.write_data;
      freg = '0;
      tgt = '0;
      fwd = 0;
      case (it.operation)
        OP_PORT_WR: begin
          if (p == PORT_LEDS) begin
            fwd = 1;
            tgt = TGT_LEDS;
          end else if (p == PORT_LCD) begin
            fwd = 1;
            tgt = TGT_LCD;
          end else if (p == PORT_SER_DATA) begin
            fwd = (d != CHAR_CR);
            tgt = TGT_SERIAL;
          end else if (p >= PORT_VIDEO_LO && p <= PORT_VIDEO_HI) begin
            fwd = 1;
            tgt = TGT_VIDEO;
            freg = p;
          end else if (p == PORT_TIMER) begin
            tmr_ctl = d;
          end else if (p == PORT_SER_CTRL) begin
            ser_ctl = d;
          end else if (p == PORT_SND_ADDR) begin
            snd_addr = d;
          end else if (p == PORT_SND_DATA) begin
            fwd = 1;
            tgt = TGT_SOUND;
            freg = snd_addr;
          end
        end
        OP_PORT_RD: begin
          if (p == PORT_VIDEO_LO) begin
            r.external_read = 1'b1;
            ext_reads++;
          end else if (p == PORT_LEDS) begin
            r.read_data = buttons;
          end else if (p == PORT_SER_CTRL) begin
            r.read_data = '0;
          end else if (p == PORT_STATUS) begin
            r.read_data = {5'b0, flags};
          end else if (p == PORT_KEYBOARD) begin
            r.read_data = BYTE_NONE;
            if (key_cnt > 0) begin
              r.read_data = keys[key_rd];
              key_rd = (key_rd + 1) % KEY_FIFO_DEPTH;
              key_cnt--;
            end
            if (key_cnt == 0) flags[FLAG_KEY] = 1'b0;
          end else if (p == PORT_TIMER) begin
            flags[FLAG_TIMER] = 1'b0;
            r.read_data = BYTE_NONE;
          end else if (p == PORT_SER_DATA) begin
            flags[FLAG_SERIAL] = 1'b0;
            if (ser_latch == CHAR_LF) ser_latch = CHAR_CR;
            r.read_data = ser_latch;
          end else begin
            r.read_data = BYTE_NONE;
          end
        end
        OP_KEY: begin
          if (key_cnt < KEY_FIFO_DEPTH) begin
            keys[key_wr] = d;
            key_wr = (key_wr + 1) % KEY_FIFO_DEPTH;
            key_cnt++;
            flags[FLAG_KEY] = 1'b1;
            r.input_accepted = 1'b1;
          end else begin
            keys_dropped++;
          end
        end
        OP_TICK: begin
          if (tmr_ctl[0]) flags[FLAG_TIMER] = 1'b1;
        end
        OP_SERIAL: begin
          if (ser_ctl[1:0] == 2'b11 && !flags[FLAG_SERIAL]) begin
            ser_latch = d;
            flags[FLAG_SERIAL] = 1'b1;
            r.input_accepted = 1'b1;
            serial_taken++;
          end
        end
        OP_BUTTON: begin
          buttons[it.button_index] = !it.button_pressed;
        end
        default: ;
      endcase
      if (fwd) begin
        r.forward_valid = 1'b1;
        r.forward_target = tgt;
        r.forward_register = freg;
        r.forward_data = d;
        forwards++;
      end
      r.irq_status = flags;
      expected_q.push_back(r);
    endfunction

    task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
        report($sformatf("result %0d %s got %0h expected %0h", results_seen, name, got, want));
      end
    endtask

    task check_result(bio_out_t got);
      bio_out_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d (%h) arrived with nothing pending", results_seen, got));
        return;
      end
      want = expected_q.pop_front();
      check_field("read_data", got.read_data, want.read_data);
      check_field("irq_status", 8'(got.irq_status), 8'(want.irq_status));
      check_field("forward_valid", 8'(got.forward_valid), 8'(want.forward_valid));
      check_field("forward_target", 8'(got.forward_target), 8'(want.forward_target));
      check_field("forward_register", got.forward_register, want.forward_register);
      check_field("forward_data", got.forward_data, want.forward_data);
      check_field("external_read", 8'(got.external_read), 8'(want.external_read));
      check_field("input_accepted", 8'(got.input_accepted), 8'(want.input_accepted));
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  bio_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  bio_out_t out_data;

  bio_scoreboard sb = new();
  int unsigned beats_sent = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit calm = 0;

  board_io_port_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, sb.expected_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) sb.note_input(in_data);
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (calm || stall_left == 0) begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 12) stall_left = gap_len() + 1;
    end else begin
      out_ready <= 1'b0;
      stall_left--;
    end
  end

  function automatic logic [7:0] any_byte();
    case ($urandom_range(0, 9))
      0: return CHAR_LF;
      1: return CHAR_CR;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_port();
    case ($urandom_range(0, 12))
      0: return PORT_LEDS;
      1: return PORT_LCD;
      2: return 8'(PORT_VIDEO_LO + $urandom_range(0, 3));
      3: return PORT_TIMER;
      4: return PORT_KEYBOARD;
      5: return PORT_SND_ADDR;
      6: return PORT_SND_DATA;
      7: return PORT_SER_CTRL;
      8: return PORT_SER_DATA;
      9: return PORT_STATUS;
      10: return PORT_VIDEO_HI;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic bio_in_t mk(logic [2:0] op, logic [7:0] port, logic [7:0] data);
    bio_in_t it;
    it.operation = op;
    it.port_address = port;
    it.write_data = data;
    it.button_index = 3'($urandom);
    it.button_pressed = 1'($urandom);
    return it;
  endfunction

  function automatic bio_in_t btn(logic [2:0] idx, logic pressed);
    bio_in_t it = mk(OP_BUTTON, 8'($urandom), 8'($urandom));
    it.button_index = idx;
    it.button_pressed = pressed;
    return it;
  endfunction

  task automatic send(bio_in_t it);
    int unsigned gap = calm ? 0 : gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  initial begin
    int unsigned n, directed;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset values, every port, every event kind but OP_KEY, undefined op codes and the corner cases
    send(mk(OP_PORT_RD, PORT_LEDS, 8'h00));
    send(mk(OP_PORT_RD, PORT_KEYBOARD, 8'h00));
    send(btn(3'd0, 1'b1));
    send(btn(3'd7, 1'b1));
    send(btn(3'd7, 1'b0));
    send(mk(OP_PORT_RD, PORT_LEDS, 8'hFF));
    send(mk(OP_PORT_WR, PORT_LEDS, 8'hFF));
    send(mk(OP_PORT_WR, PORT_LCD, 8'h00));
    send(mk(OP_PORT_WR, PORT_SER_DATA, CHAR_CR));
    send(mk(OP_PORT_WR, PORT_SER_DATA, 8'h41));
    send(mk(OP_PORT_WR, PORT_VIDEO_HI, 8'hA5));
    send(mk(OP_PORT_WR, PORT_SND_ADDR, 8'h5A));
    send(mk(OP_PORT_WR, PORT_SND_DATA, 8'h3C));
    send(mk(OP_PORT_WR, PORT_UNMAPPED, 8'h77));
    send(mk(OP_PORT_WR, PORT_TIMER, 8'h01));
    send(mk(OP_TICK, PORT_TIMER, 8'h00));
    send(mk(OP_PORT_RD, PORT_TIMER, 8'h00));
    send(mk(OP_PORT_WR, PORT_SER_CTRL, 8'h03));
    send(mk(OP_SERIAL, PORT_SER_DATA, CHAR_LF));
    send(mk(OP_SERIAL, PORT_SER_DATA, 8'h55));
    send(mk(OP_PORT_RD, PORT_STATUS, 8'h00));
    send(mk(OP_PORT_RD, PORT_SER_DATA, 8'h00));
    send(mk(OP_PORT_RD, PORT_VIDEO_LO, 8'h00));
    send(mk(OP_PORT_RD, PORT_SER_CTRL, 8'h00));
    send(mk(OP_PORT_RD, PORT_UNMAPPED, 8'h00));
    send(mk(OP_UNDEF_LO, PORT_LEDS, 8'hFF));
    send(mk(OP_UNDEF_HI, PORT_KEYBOARD, 8'h00));
    directed = beats_sent;
    wait_drained();

    // overfill the keyboard FIFO, then read it past empty
    repeat (KEY_FIFO_DEPTH + 2) send(mk(OP_KEY, pick_port(), 8'($urandom)));
    repeat (KEY_FIFO_DEPTH + 2) send(mk(OP_PORT_RD, PORT_KEYBOARD, 8'($urandom)));

    while (beats_sent < TOTAL_BEATS) begin
      calm = ($urandom_range(0, 15) == 0);
      case ($urandom_range(0, 9))
        0, 1: begin
          n = $urandom_range(1, 20);
          repeat (n) send(mk(OP_KEY, pick_port(), 8'($urandom)));
          repeat ($urandom_range(0, n + 2)) begin
            send(mk(OP_PORT_RD, ($urandom_range(0, 4) == 0) ? PORT_STATUS : PORT_KEYBOARD,
                    8'($urandom)));
          end
        end
        2: begin
          if ($urandom_range(0, 3) != 0) begin
            send(mk(OP_PORT_WR, PORT_SER_CTRL, {6'($urandom), 2'b11}));
          end else begin
            send(mk(OP_PORT_WR, PORT_SER_CTRL, 8'($urandom)));
          end
          repeat ($urandom_range(1, 3)) send(mk(OP_SERIAL, pick_port(), any_byte()));
          if ($urandom_range(0, 3) != 0) send(mk(OP_PORT_RD, PORT_SER_DATA, 8'($urandom)));
        end
        3: begin
          send(mk(OP_PORT_WR, PORT_TIMER, {7'($urandom), ($urandom_range(0, 3) != 0)}));
          repeat ($urandom_range(1, 3)) send(mk(OP_TICK, pick_port(), 8'($urandom)));
          send(mk(OP_PORT_RD, PORT_STATUS, 8'($urandom)));
          if ($urandom_range(0, 9) < 7) send(mk(OP_PORT_RD, PORT_TIMER, 8'($urandom)));
        end
        4: begin
          send(mk(OP_PORT_WR, PORT_SND_ADDR, 8'($urandom)));
          repeat ($urandom_range(1, 3)) send(mk(OP_PORT_WR, PORT_SND_DATA, 8'($urandom)));
        end
        5: begin
          repeat ($urandom_range(1, 4)) send(btn(3'($urandom), 1'($urandom)));
          send(mk(OP_PORT_RD, PORT_LEDS, 8'($urandom)));
        end
        6, 7: begin
          repeat ($urandom_range(1, 6)) begin
            send(mk(3'($urandom_range(0, 7)), pick_port(), any_byte()));
          end
        end
        8: begin
          repeat ($urandom_range(1, 4)) send(mk(OP_PORT_WR, pick_port(), any_byte()));
        end
        default: begin
          repeat ($urandom_range(1, 4)) send(mk(OP_PORT_RD, pick_port(), 8'($urandom)));
        end
      endcase
      // hold off now and then until the pipeline is empty
      if ($urandom_range(0, 39) == 0) wait_drained();
    end

    calm = 0;
    wait_drained();
    repeat (6) @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
    end

    $display("Sent %0d beats (%0d directed) over all six events and unknown codes; %0d checked.",
             beats_sent, directed, sb.results_seen);
    $display("Key drops on full FIFO %0d, serial bytes latched %0d, forwards %0d, video reads %0d.",
             sb.keys_dropped, sb.serial_taken, sb.forwards, sb.ext_reads);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
